/* rtl/assert_macros.svh */
// Assertion macros for the design. Simulation builds get checked properties;
// synthesis builds define SYNTH and the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/adm_pkg.sv */
package adm_pkg;

    localparam int DEF_MAX_NAME_BYTES = 16;

    localparam int DATA_W        = 8;
    localparam int TARGET_LEN_W  = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int BYTES_PER_REG = CFG_DATA_W / DATA_W;

    localparam logic [DATA_W-1:0] MAX_REPORT_BYTES   = 8'd255;
    localparam logic [DATA_W-1:0] OFFSET_SATURATE    = 8'd255;
    localparam logic [DATA_W-1:0] TYPE_COMPLETE_NAME = 8'h0B;
    localparam logic [DATA_W-1:0] TYPE_SHORT_NAME    = 8'h0A;

    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LOW   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_HIGH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_LEN = 2'd2;

    typedef enum logic [2:0] {
        PH_LENGTH = 3'b001,
        PH_TYPE   = 3'b010,
        PH_DATA   = 3'b100
    } phase_t;

    // Qualifiers for one byte handed to the walker.
    typedef struct packed {
        logic valid;
        logic last;
    } step_t;

endpackage

/* rtl/adm_walker.sv */
module adm_walker #(
    parameter int MAX_NAME_BYTES = adm_pkg::DEF_MAX_NAME_BYTES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  adm_pkg::step_t                     step,
    input  logic [adm_pkg::DATA_W-1:0]         data_byte,
    input  logic [adm_pkg::DATA_W-1:0]         report_length,
    input  logic [MAX_NAME_BYTES*adm_pkg::DATA_W-1:0] name_bytes,
    input  logic [adm_pkg::TARGET_LEN_W-1:0]   target_length,
    output logic                               found
);
    import adm_pkg::*;

    localparam int IDX_W = $clog2(MAX_NAME_BYTES + 1);
    localparam int SEL_W = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
    localparam logic [TARGET_LEN_W-1:0] MAX_TL = TARGET_LEN_W'(MAX_NAME_BYTES);

    logic [DATA_W-1:0] byte_offset_reg, byte_offset_next;
    phase_t            phase_reg, phase_next;
    logic [DATA_W-1:0] struct_end_reg, struct_end_next;
    logic [IDX_W-1:0]  name_index_reg, name_index_next;
    logic              still_matching_reg, still_matching_next;
    logic              match_latched_reg, match_latched_next;
    logic              walk_stopped_reg, walk_stopped_next;

    logic [IDX_W-1:0]  tl_eff;
    logic [DATA_W-1:0] len_eff;
    logic [DATA_W:0]   length_sum;
    logic [DATA_W:0]   name_left;
    logic [DATA_W-1:0] target_byte;
    logic [IDX_W-1:0]  index_inc;
    logic              is_name_type;
    logic              found_now_set;

    assign tl_eff  = (target_length > MAX_TL) ? IDX_W'(MAX_NAME_BYTES) : IDX_W'(target_length);
    assign len_eff = (report_length > MAX_REPORT_BYTES) ? MAX_REPORT_BYTES : report_length;
    assign length_sum   = {1'b0, byte_offset_reg} + {1'b0, data_byte};
    // A type byte that arrives past the structure end (bytes were skipped) gives a
    // borrow here, which reads as a very long name part.
    assign name_left    = {1'b0, struct_end_reg} - {1'b0, byte_offset_reg};
    assign target_byte  = name_bytes[DATA_W*name_index_reg[SEL_W-1:0] +: DATA_W];
    assign index_inc    = name_index_reg + IDX_W'(1);
    assign is_name_type = (data_byte == TYPE_COMPLETE_NAME) || (data_byte == TYPE_SHORT_NAME);

    always_comb
    begin
        byte_offset_next    = byte_offset_reg;
        phase_next          = phase_reg;
        struct_end_next     = struct_end_reg;
        name_index_next     = name_index_reg;
        still_matching_next = still_matching_reg;
        match_latched_next  = match_latched_reg;
        walk_stopped_next   = walk_stopped_reg;

        if (step.valid)
        begin
            if (!walk_stopped_reg && (byte_offset_reg < len_eff))
            begin
                unique case (phase_reg)
                    PH_LENGTH:
                    begin
                        if ((data_byte == '0) || (length_sum >= {1'b0, len_eff}))
                        begin
                            walk_stopped_next = 1'b1;
                        end
                        else
                        begin
                            struct_end_next     = length_sum[DATA_W-1:0];
                            still_matching_next = 1'b0;
                            name_index_next     = '0;
                            phase_next          = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        if (is_name_type && (name_left >= (DATA_W+1)'(tl_eff)))
                        begin
                            still_matching_next = 1'b1;
                            name_index_next     = '0;
                            if (tl_eff == '0)
                            begin
                                match_latched_next = 1'b1;
                            end
                        end
                        phase_next = (byte_offset_reg == struct_end_reg) ? PH_LENGTH : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (still_matching_reg && (name_index_reg < tl_eff))
                        begin
                            if (data_byte != target_byte)
                            begin
                                still_matching_next = 1'b0;
                            end
                            else
                            begin
                                name_index_next = index_inc;
                                if (index_inc == tl_eff)
                                begin
                                    match_latched_next = 1'b1;
                                end
                            end
                        end
                        if (byte_offset_reg == struct_end_reg)
                        begin
                            phase_next = PH_LENGTH;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LENGTH;
                    end
                endcase
            end

            if (byte_offset_reg != OFFSET_SATURATE)
            begin
                byte_offset_next = byte_offset_reg + DATA_W'(1);
            end

            if (step.last)
            begin
                byte_offset_next    = '0;
                phase_next          = PH_LENGTH;
                struct_end_next     = '0;
                name_index_next     = '0;
                still_matching_next = 1'b0;
                match_latched_next  = 1'b0;
                walk_stopped_next   = 1'b0;
            end
        end
    end

    // Result of the byte being taken: the match flag after this byte is walked.
    assign found = match_latched_reg | found_now_set;

    always_comb
    begin
        found_now_set = 1'b0;
        if (!walk_stopped_reg && (byte_offset_reg < len_eff))
        begin
            if ((phase_reg == PH_TYPE) && is_name_type
                && (name_left >= (DATA_W+1)'(tl_eff)) && (tl_eff == '0))
            begin
                found_now_set = 1'b1;
            end
            if ((phase_reg == PH_DATA) && still_matching_reg && (name_index_reg < tl_eff)
                && (data_byte == target_byte) && (index_inc == tl_eff))
            begin
                found_now_set = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg    <= '0;
            phase_reg          <= PH_LENGTH;
            struct_end_reg     <= '0;
            name_index_reg     <= '0;
            still_matching_reg <= 1'b0;
            match_latched_reg  <= 1'b0;
            walk_stopped_reg   <= 1'b0;
        end
        else
        begin
            byte_offset_reg    <= byte_offset_next;
            phase_reg          <= phase_next;
            struct_end_reg     <= struct_end_next;
            name_index_reg     <= name_index_next;
            still_matching_reg <= still_matching_next;
            match_latched_reg  <= match_latched_next;
            walk_stopped_reg   <= walk_stopped_next;
        end
    end

endmodule

/* rtl/adv_data_name_matcher_top.sv */
// A result is registered in the output register, or in the skid slot while that is stalled.
// Throughput: one report byte per cycle unless in_stall; parse state updates per transfer.
// A two-entry output (output register plus skid) lets bytes keep flowing while a result waits.
// Reset (rst_n, asynchronous, active low) clears the walk state, the output and skid flags,
// and all configuration registers to zero.
`include "assert_macros.svh"

module adv_data_name_matcher_top #(
    parameter int MAX_NAME_BYTES = adm_pkg::DEF_MAX_NAME_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration write port.
    input  logic                              cfg_write_enable,
    input  logic [adm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [adm_pkg::CFG_DATA_W-1:0]    cfg_data,

    // Report byte channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [adm_pkg::DATA_W-1:0]        data_byte,
    input  logic [adm_pkg::DATA_W-1:0]        report_length,
    input  logic                              last_byte,

    // Result channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found
);
    import adm_pkg::*;

    // Only the name bytes that the block can ever compare are stored.
    logic [MAX_NAME_BYTES*DATA_W-1:0] name_reg;
    logic [TARGET_LEN_W-1:0]          target_len_reg;

    logic   out_valid_reg, out_valid_next;
    logic   out_found_reg, out_found_next;
    logic   skid_valid_reg, skid_valid_next;
    logic   skid_found_reg, skid_found_next;

    step_t  step;
    logic   walk_found;
    logic   in_xfer;
    logic   out_xfer;
    logic   result_new;

    // Configuration registers. Writes to an index past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_reg       <= '0;
            target_len_reg <= '0;
        end
        else if (cfg_write_enable)
        begin
            for (int i = 0; i < MAX_NAME_BYTES; i++)
            begin
                if ((i < BYTES_PER_REG) && (cfg_index == REG_NAME_LOW))
                begin
                    name_reg[DATA_W*i +: DATA_W] <= cfg_data[DATA_W*(i % BYTES_PER_REG) +: DATA_W];
                end
                if ((i >= BYTES_PER_REG) && (cfg_index == REG_NAME_HIGH))
                begin
                    name_reg[DATA_W*i +: DATA_W] <= cfg_data[DATA_W*(i % BYTES_PER_REG) +: DATA_W];
                end
            end
            if (cfg_index == REG_TARGET_LEN)
            begin
                target_len_reg <= cfg_data[TARGET_LEN_W-1:0];
            end
        end
    end

    // The byte channel stalls only when both result slots are occupied.
    assign in_stall   = skid_valid_reg;
    assign in_xfer    = in_valid & ~in_stall;
    assign out_xfer   = out_valid_reg & ~out_stall;
    assign result_new = in_xfer & last_byte;

    assign step.valid = in_xfer;
    assign step.last  = last_byte;

    adm_walker #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (data_byte),
        .report_length (report_length),
        .name_bytes    (name_reg),
        .target_length (target_len_reg),
        .found         (walk_found)
    );

    // Output register with a skid slot behind it. A new result goes to the output
    // register when it is empty or being drained this cycle; otherwise it parks
    // in the skid slot, which then moves forward on the next output transfer.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        skid_valid_next = skid_valid_reg;
        skid_found_next = skid_found_reg;

        if (skid_valid_reg)
        begin
            if (out_xfer)
            begin
                out_found_next  = skid_found_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (result_new)
        begin
            if (out_valid_reg && !out_xfer)
            begin
                skid_valid_next = 1'b1;
                skid_found_next = walk_found;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_found_next = walk_found;
            end
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg  <= out_found_next;
        skid_found_reg <= skid_found_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;

    // The skid slot is only ever filled behind an occupied output register.
    `ASSERT_SAME(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    // A transferred last byte always leaves a result waiting in the next cycle.
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, in_valid && !in_stall && last_byte, out_valid)
    // A parked result stays parked while the output side is stalled.
    `ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_valid_reg && out_stall, skid_valid_reg)

endmodule
